>>> rtl/wgri_pkg.sv
// Package with shared types and constants for the weighted-gather RGB interpolator.
package wgri_pkg;

    localparam int SRC_AW   = 12;
    localparam int CON_AW   = 12;
    localparam int GRP_AW   = 10;
    localparam int CNT_W    = 13;
    localparam int GCNT_W   = 11;
    localparam int DSZ_W    = 13;
    localparam logic [CNT_W-1:0]  CONTRIB_DEPTH = 13'd4096;
    localparam logic [GCNT_W-1:0] GROUP_DEPTH   = 11'd1024;
    localparam logic [DSZ_W-1:0]  DEST_DEPTH    = 13'd4096;

    typedef enum logic [2:0] {
        FUNC_OPEN   = 3'd0,
        FUNC_ADD    = 3'd1,
        FUNC_CLOSE  = 3'd2,
        FUNC_WRITE  = 3'd3,
        FUNC_INTERP = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BAD_IDX  = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GRP,
        S_CON,
        S_PIX,
        S_MAC,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [2:0]  func;
        logic [11:0] src_index;
        logic [15:0] weight;
        logic [11:0] dest_offset_a;
        logic [11:0] dest_offset_b;
        logic [11:0] dest_offset_c;
        logic [23:0] pixel_color;
        logic [9:0]  group_index;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] out_dest_a;
        logic [11:0] out_dest_b;
        logic [11:0] out_dest_c;
        logic [31:0] out_color;
        logic [12:0] dest_size;
        logic [10:0] group_count;
    } out_item_t;

    // Stored group: begin, end, three offsets.
    typedef struct packed {
        logic [CNT_W-1:0] first;
        logic [CNT_W-1:0] last;
        logic [11:0]      da;
        logic [11:0]      db;
        logic [11:0]      dc;
    } group_t;

    // Controls for the shared multiply-accumulate unit.
    typedef struct packed {
        logic        clear;
        logic        enable;
        logic [7:0]  pix_byte;
        logic [15:0] weight;
        logic [1:0]  chan;
    } mac_ctrl_t;

endpackage

>>> rtl/wgri_mac.sv
// Shared 8x16 multiply-accumulate unit with three 32-bit channel accumulators.
module wgri_mac (
    input  logic                aclk,
    input  wgri_pkg::mac_ctrl_t ctrl,
    output logic [31:0]         color
);

    logic [31:0] acc_reg [3];
    logic [23:0] prod;

    assign prod = {16'd0, ctrl.pix_byte} * {8'd0, ctrl.weight};

    // One channel product is added per cycle while enable is set.
    always_ff @(posedge aclk) begin
        if (ctrl.clear) begin
            acc_reg[0] <= '0;
            acc_reg[1] <= '0;
            acc_reg[2] <= '0;
        end else if (ctrl.enable && ctrl.chan != 2'd3) begin
            acc_reg[ctrl.chan] <= acc_reg[ctrl.chan] + {8'd0, prod};
        end
    end

    // Pack the channels as red, green and blue sums.
    assign color = {16'd0, acc_reg[0][31:16]} + {8'd0, acc_reg[1][31:16], 8'd0}
                 + {8'd0, acc_reg[2][23:16], 16'd0};

endmodule

>>> rtl/weighted_gather_rgb_interpolator.sv
// Top level of the weighted-gather RGB interpolator.
// The s_ channel takes one command beat; the m_ channel returns one result
// beat for each command. Both use valid/ready handshakes.
// Table commands (open, add, close, write pixel) and a rejected interpolate
// go from the group state straight to the done state.
// Interpolate reads the group record, then for each contributor reads the
// contributor table and the source pixel memory and runs the shared
// multiplier over three channels in turn, as there is a single multiplier.
// One command is in flight at a time; s_ready is low until its result beat
// has been registered, and the result register holds while m_ready is low.
// A new command is taken as soon as the result is waiting, but its own
// result waits until the previous one has left the result register.
// Synchronous active-low reset clears the counters and control state;
// the memories hold no reset value and need no clearing pass.
module weighted_gather_rgb_interpolator (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  wgri_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output wgri_pkg::out_item_t m_data
);

    wgri_pkg::state_t  state_reg, state_next;
    wgri_pkg::in_item_t cmd_reg;
    wgri_pkg::out_item_t out_reg;
    logic out_valid_reg;

    logic [wgri_pkg::CNT_W-1:0]  ccount_reg, ccount_next;
    logic [wgri_pkg::GCNT_W-1:0] gcount_reg, gcount_next;
    logic [wgri_pkg::CNT_W-1:0]  open_reg, open_next;
    logic [wgri_pkg::DSZ_W-1:0]  dsize_reg, dsize_next;

    logic [wgri_pkg::CNT_W-1:0]  j_reg, j_next, j_cur;
    logic [1:0]  chan_reg, chan_next;
    logic [1:0]  status_next;
    logic [1:0]  status_reg;
    logic [31:0] color;

    // The contributor pointer starts at the group's first entry.
    logic first_con_reg;

    logic [23:0] src_mem [1 << wgri_pkg::SRC_AW];
    logic [27:0] con_mem [1 << wgri_pkg::CON_AW];
    wgri_pkg::group_t grp_mem [1 << wgri_pkg::GRP_AW];
    logic [23:0] src_rd_reg;
    logic [27:0] con_rd_reg;
    wgri_pkg::group_t grp_rd_reg;
    wgri_pkg::mac_ctrl_t mac;

    logic accept, finish;
    logic [wgri_pkg::DSZ_W-1:0] s_a, s_b, s_c, m_ab, m_abc;

    assign s_ready = (state_reg == wgri_pkg::S_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // On the first contributor cycle the pointer comes from the group record.
    assign j_cur = first_con_reg ? grp_rd_reg.first : j_reg;

    // Offsets plus one, saturated at the destination depth.
    function automatic logic [wgri_pkg::DSZ_W-1:0] sat1(input logic [11:0] o);
        logic [wgri_pkg::DSZ_W-1:0] s;
        s = {1'b0, o} + 13'd1;
        return (s > wgri_pkg::DEST_DEPTH) ? wgri_pkg::DEST_DEPTH : s;
    endfunction

    assign s_a   = sat1(cmd_reg.dest_offset_a);
    assign s_b   = sat1(cmd_reg.dest_offset_b);
    assign s_c   = sat1(cmd_reg.dest_offset_c);
    assign m_ab  = (s_a > s_b) ? s_a : s_b;
    assign m_abc = (m_ab > s_c) ? m_ab : s_c;

    // Memory writes and registered reads.
    always_ff @(posedge aclk) begin
        if (state_reg == wgri_pkg::S_GRP && cmd_reg.func == wgri_pkg::FUNC_WRITE) begin
            src_mem[cmd_reg.src_index] <= cmd_reg.pixel_color;
        end
        if (state_reg == wgri_pkg::S_GRP && cmd_reg.func == wgri_pkg::FUNC_ADD
                && ccount_reg < wgri_pkg::CONTRIB_DEPTH) begin
            con_mem[ccount_reg[wgri_pkg::CON_AW-1:0]] <= {cmd_reg.src_index, cmd_reg.weight};
        end
        if (state_reg == wgri_pkg::S_GRP && cmd_reg.func == wgri_pkg::FUNC_CLOSE
                && gcount_reg < wgri_pkg::GROUP_DEPTH && ccount_reg > open_reg) begin
            grp_mem[gcount_reg[wgri_pkg::GRP_AW-1:0]] <= {open_reg, ccount_reg,
                cmd_reg.dest_offset_a, cmd_reg.dest_offset_b, cmd_reg.dest_offset_c};
        end
        grp_rd_reg <= grp_mem[cmd_reg.group_index];
        con_rd_reg <= con_mem[j_cur[wgri_pkg::CON_AW-1:0]];
        src_rd_reg <= src_mem[con_rd_reg[27:16]];
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            wgri_pkg::S_IDLE: if (accept) state_next = wgri_pkg::S_GRP;
            wgri_pkg::S_GRP: begin
                if (cmd_reg.func == wgri_pkg::FUNC_INTERP && {1'b0, cmd_reg.group_index} < gcount_reg)
                    state_next = wgri_pkg::S_CON;
                else
                    state_next = wgri_pkg::S_DONE;
            end
            wgri_pkg::S_CON: begin
                if (j_cur >= grp_rd_reg.last) state_next = wgri_pkg::S_DONE;
                else                          state_next = wgri_pkg::S_PIX;
            end
            wgri_pkg::S_PIX: state_next = wgri_pkg::S_MAC;
            wgri_pkg::S_MAC: if (chan_reg == 2'd2) state_next = wgri_pkg::S_CON;
            wgri_pkg::S_DONE: if (!out_valid_reg || m_ready) state_next = wgri_pkg::S_IDLE;
            default: state_next = wgri_pkg::S_IDLE;
        endcase
    end

    // Datapath and counter updates.
    always_comb begin
        ccount_next = ccount_reg;
        gcount_next = gcount_reg;
        open_next   = open_reg;
        dsize_next  = dsize_reg;
        j_next      = j_reg;
        chan_next   = chan_reg;
        status_next = wgri_pkg::ST_OK;
        mac.clear   = 1'b0;
        mac.enable  = 1'b0;
        mac.weight  = con_rd_reg[15:0];
        mac.chan    = chan_reg;
        case (chan_reg)
            2'd0:    mac.pix_byte = src_rd_reg[7:0];
            2'd1:    mac.pix_byte = src_rd_reg[15:8];
            default: mac.pix_byte = src_rd_reg[23:16];
        endcase
        finish = (state_reg == wgri_pkg::S_DONE) && (!out_valid_reg || m_ready);
        case (cmd_reg.func)
            wgri_pkg::FUNC_ADD:
                if (ccount_reg >= wgri_pkg::CONTRIB_DEPTH) status_next = wgri_pkg::ST_FULL;
            wgri_pkg::FUNC_CLOSE:
                if (gcount_reg >= wgri_pkg::GROUP_DEPTH)  status_next = wgri_pkg::ST_FULL;
                else if (ccount_reg <= open_reg)          status_next = wgri_pkg::ST_EMPTY;
            wgri_pkg::FUNC_INTERP:
                if ({1'b0, cmd_reg.group_index} >= gcount_reg)
                    status_next = wgri_pkg::ST_BAD_IDX;
            default: status_next = wgri_pkg::ST_OK;
        endcase
        case (state_reg)
            wgri_pkg::S_GRP: begin
                mac.clear = 1'b1;
                chan_next = 2'd0;
                if (cmd_reg.func == wgri_pkg::FUNC_OPEN) open_next = ccount_reg;
                if (cmd_reg.func == wgri_pkg::FUNC_ADD && status_next == wgri_pkg::ST_OK)
                    ccount_next = ccount_reg + 13'd1;
                if (cmd_reg.func == wgri_pkg::FUNC_CLOSE && status_next == wgri_pkg::ST_OK) begin
                    gcount_next = gcount_reg + 11'd1;
                    if (m_abc > dsize_reg) dsize_next = m_abc;
                end
            end
            wgri_pkg::S_MAC: begin
                mac.enable = 1'b1;
                chan_next  = (chan_reg == 2'd2) ? 2'd0 : chan_reg + 2'd1;
                if (chan_reg == 2'd2) j_next = j_reg + 13'd1;
            end
            default: ;
        endcase
    end

    // Registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= wgri_pkg::S_IDLE;
            ccount_reg    <= '0;
            gcount_reg    <= '0;
            open_reg      <= '0;
            dsize_reg     <= '0;
            out_valid_reg <= 1'b0;
            chan_reg      <= '0;
            j_reg         <= '0;
            first_con_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            ccount_reg <= ccount_next;
            gcount_reg <= gcount_next;
            open_reg   <= open_next;
            dsize_reg  <= dsize_next;
            chan_reg   <= chan_next;
            first_con_reg <= (state_reg == wgri_pkg::S_GRP);
            if (first_con_reg) j_reg <= grp_rd_reg.first;
            else               j_reg <= j_next;
            if (finish)             out_valid_reg <= 1'b1;
            else if (m_ready)       out_valid_reg <= 1'b0;
        end
    end

    // Command capture and result register.
    always_ff @(posedge aclk) begin
        if (accept) cmd_reg <= s_data;
        if (state_reg == wgri_pkg::S_GRP) status_reg <= status_next;
        if (finish) begin
            out_reg.status      <= status_reg;
            out_reg.dest_size   <= dsize_reg;
            out_reg.group_count <= gcount_reg;
            if (cmd_reg.func == wgri_pkg::FUNC_INTERP && status_reg == wgri_pkg::ST_OK) begin
                out_reg.out_dest_a <= grp_rd_reg.da;
                out_reg.out_dest_b <= grp_rd_reg.db;
                out_reg.out_dest_c <= grp_rd_reg.dc;
                out_reg.out_color  <= color;
            end else begin
                out_reg.out_dest_a <= '0;
                out_reg.out_dest_b <= '0;
                out_reg.out_dest_c <= '0;
                out_reg.out_color  <= '0;
            end
        end
    end

    wgri_mac u_mac (
        .aclk  (aclk),
        .ctrl  (mac),
        .color (color)
    );

endmodule

>>> test/tb_weighted_gather_rgb_interpolator.sv
// Self-checking testbench for the weighted-gather RGB interpolator.
`timescale 1ns / 100ps

module tb_weighted_gather_rgb_interpolator;

    localparam int SRC_N = 4096;
    localparam int CON_N = 4096;
    localparam int GRP_N = 1024;
    localparam int DST_N = 4096;
    localparam int EXP_N = 4096;
    localparam int ROW_N = 64;
    localparam int STALL_LIMIT = 100000;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    wgri_pkg::in_item_t  s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    wgri_pkg::out_item_t m_data;

    weighted_gather_rgb_interpolator u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    // Predictor state: a copy of the tables and counters.
    logic [23:0]      pix_mem [SRC_N];
    bit               pix_written [SRC_N];
    logic [11:0]      con_src [CON_N];
    logic [15:0]      con_wt [CON_N];
    wgri_pkg::group_t grp_mem [GRP_N];
    int unsigned      con_count;
    int unsigned      grp_count;
    int unsigned      open_start;
    int unsigned      dst_size;

    // Expected results in send order, with write and read positions.
    wgri_pkg::out_item_t exp_mem [EXP_N];
    int          exp_wr = 0;
    int          exp_rd = 0;
    int          mismatches = 0;
    bit          timed_out = 1'b0;
    int          idle_cycles = 0;

    function automatic void grow_dest(input logic [11:0] off);
        int unsigned s;
        s = off + 1;
        if (s > DST_N) s = DST_N;
        if (s > dst_size) dst_size = s;
    endfunction

    // Compute the result of one command and update the predictor state.
    function automatic wgri_pkg::out_item_t predict_result(input wgri_pkg::in_item_t it);
        wgri_pkg::out_item_t r;
        logic [31:0] sr, sg, sb;
        logic [23:0] c;
        r = '0;
        case (it.func)
            wgri_pkg::FUNC_OPEN: open_start = con_count;
            wgri_pkg::FUNC_ADD: begin
                if (con_count >= CON_N) begin
                    r.status = wgri_pkg::ST_FULL;
                end else begin
                    con_src[con_count] = it.src_index;
                    con_wt[con_count] = it.weight;
                    con_count++;
                end
            end
            wgri_pkg::FUNC_CLOSE: begin
                if (grp_count >= GRP_N) begin
                    r.status = wgri_pkg::ST_FULL;
                end else if (con_count <= open_start) begin
                    r.status = wgri_pkg::ST_EMPTY;
                end else begin
                    grp_mem[grp_count] = '{first: 13'(open_start), last: 13'(con_count),
                        da: it.dest_offset_a, db: it.dest_offset_b, dc: it.dest_offset_c};
                    grp_count++;
                    grow_dest(it.dest_offset_a);
                    grow_dest(it.dest_offset_b);
                    grow_dest(it.dest_offset_c);
                end
            end
            wgri_pkg::FUNC_WRITE: begin
                pix_mem[it.src_index] = it.pixel_color;
                pix_written[it.src_index] = 1'b1;
            end
            wgri_pkg::FUNC_INTERP: begin
                if (it.group_index >= grp_count) begin
                    r.status = wgri_pkg::ST_BAD_IDX;
                end else begin
                    sr = 0;
                    sg = 0;
                    sb = 0;
                    for (int j = grp_mem[it.group_index].first;
                         j < grp_mem[it.group_index].last; j++) begin
                        c = pix_mem[con_src[j]];
                        sr += c[7:0] * con_wt[j];
                        sg += c[15:8] * con_wt[j];
                        sb += c[23:16] * con_wt[j];
                    end
                    r.out_color = (sr >> 16) + ((sg >> 16) << 8) + (sb & 32'hff0000);
                    r.out_dest_a = grp_mem[it.group_index].da;
                    r.out_dest_b = grp_mem[it.group_index].db;
                    r.out_dest_c = grp_mem[it.group_index].dc;
                end
            end
            default: ;
        endcase
        r.dest_size = 13'(dst_size);
        r.group_count = 11'(grp_count);
        return r;
    endfunction

    // True when every contributor of the group reads a written pixel.
    function automatic bit group_is_readable(input int g);
        for (int j = grp_mem[g].first; j < grp_mem[g].last; j++)
            if (!pix_written[con_src[j]]) return 1'b0;
        return 1'b1;
    endfunction

    // Send one beat, honoring the valid/ready rule, and record its prediction.
    // Valid stays high after the beat; the next beat or an idle cycle replaces it.
    task automatic send_beat(input wgri_pkg::in_item_t it);
        s_valid <= 1'b1;
        s_data <= it;
        exp_mem[exp_wr] = predict_result(it);
        exp_wr++;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Drive valid low and wait for a clock edge, offering no beat.
    task automatic idle_cycle();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Random gap between bursts of beats.
    int burst_left = 0;
    task automatic pace_sender();
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            repeat ($urandom_range(0, 6)) idle_cycle();
        end
        burst_left--;
    endtask

    function automatic wgri_pkg::in_item_t rand_noise_fields();
        wgri_pkg::in_item_t it;
        it.func = wgri_pkg::FUNC_OPEN;
        it.src_index = 12'($urandom);
        it.weight = 16'($urandom);
        it.dest_offset_a = 12'($urandom);
        it.dest_offset_b = 12'($urandom);
        it.dest_offset_c = 12'($urandom);
        it.pixel_color = 24'($urandom);
        it.group_index = 10'($urandom);
        return it;
    endfunction

    // Receiver stall pattern: long ready runs alternating with stall runs.
    initial begin
        int run;
        @(posedge aclk iff aresetn);
        forever begin
            run = $urandom_range(1, 30);
            m_ready <= 1'b1;
            repeat (run) @(posedge aclk);
            run = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
            if (run > 0) begin
                m_ready <= 1'b0;
                repeat (run) @(posedge aclk);
            end
        end
    end

    // Result checker.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (exp_rd >= exp_wr) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result beat %h", m_data);
            end else begin
                wgri_pkg::out_item_t e;
                e = exp_mem[exp_rd];
                exp_rd++;
                if (e !== m_data) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Mismatch: expected st=%0d a=%h b=%h c=%h col=%h ds=%0d gc=%0d",
                            e.status, e.out_dest_a, e.out_dest_b, e.out_dest_c,
                            e.out_color, e.dest_size, e.group_count);
                        $display("          got      st=%0d a=%h b=%h c=%h col=%h ds=%0d gc=%0d",
                            m_data.status, m_data.out_dest_a, m_data.out_dest_b,
                            m_data.out_dest_c, m_data.out_color, m_data.dest_size,
                            m_data.group_count);
                    end
                end
            end
        end
    end

    // Watchdog on cycles with no beat accepted on either side.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("[weighted_gather_rgb_interpolator] ERROR");
            $finish;
        end
    end

    // Directed rows: command and, where obvious, the expected result.
    typedef struct {
        wgri_pkg::in_item_t  cmd;
        bit                  has_result;
        wgri_pkg::out_item_t result;
    } row_t;

    function automatic wgri_pkg::in_item_t mk(input wgri_pkg::func_t f,
                                              input logic [11:0] si,
                                              input logic [15:0] w, input logic [11:0] a,
                                              input logic [11:0] b, input logic [11:0] c,
                                              input logic [23:0] px, input logic [9:0] gi);
        wgri_pkg::in_item_t it;
        it = '{func: f, src_index: si, weight: w, dest_offset_a: a,
               dest_offset_b: b, dest_offset_c: c, pixel_color: px, group_index: gi};
        return it;
    endfunction

    function automatic wgri_pkg::out_item_t res(input wgri_pkg::status_t st, input int ds,
                                                input int gc);
        wgri_pkg::out_item_t r;
        r = '0;
        r.status = st;
        r.dest_size = 13'(ds);
        r.group_count = 11'(gc);
        return r;
    endfunction

    row_t directed [ROW_N];
    int   n_rows = 0;

    function automatic void add_row(input wgri_pkg::in_item_t cmd, input bit has_result,
                                    input wgri_pkg::out_item_t result);
        directed[n_rows] = '{cmd, has_result, result};
        n_rows++;
    endfunction

    initial begin
        wgri_pkg::in_item_t  it;
        int                  kind, n, g;
        wgri_pkg::out_item_t typed;

        for (int i = 0; i < SRC_N; i++) pix_written[i] = 1'b0;
        con_count = 0;
        grp_count = 0;
        open_start = 0;
        dst_size = 0;

        // Interpolate after reset, empty close, and unknown funcs.
        add_row(mk(wgri_pkg::FUNC_INTERP, 0, 0, 0, 0, 0, 0, 0), 1,
                res(wgri_pkg::ST_BAD_IDX, 0, 0));
        add_row(mk(wgri_pkg::FUNC_CLOSE, 0, 0, 5, 5, 5, 0, 0), 1,
                res(wgri_pkg::ST_EMPTY, 0, 0));
        add_row(mk(wgri_pkg::func_t'(3'd5), 12'hfff, 16'hffff, 12'hfff, 12'hfff,
                   12'hfff, 24'hffffff, 10'h3ff), 1, res(wgri_pkg::ST_OK, 0, 0));
        add_row(mk(wgri_pkg::func_t'(3'd7), 0, 0, 0, 0, 0, 0, 0), 1,
                res(wgri_pkg::ST_OK, 0, 0));
        // Extreme pixels.
        add_row(mk(wgri_pkg::FUNC_WRITE, 0, 0, 0, 0, 0, 24'hffffff, 0), 1,
                res(wgri_pkg::ST_OK, 0, 0));
        add_row(mk(wgri_pkg::FUNC_WRITE, 12'hfff, 0, 0, 0, 0, 24'h000000, 0), 1,
                res(wgri_pkg::ST_OK, 0, 0));
        add_row(mk(wgri_pkg::FUNC_WRITE, 12'h555, 0, 0, 0, 0, 24'h123456, 0), 0, '0);
        // Close without open: group starts at contributor zero.
        add_row(mk(wgri_pkg::FUNC_ADD, 0, 16'hffff, 0, 0, 0, 0, 0), 1,
                res(wgri_pkg::ST_OK, 0, 0));
        add_row(mk(wgri_pkg::FUNC_ADD, 0, 16'hffff, 0, 0, 0, 0, 0), 0, '0);
        add_row(mk(wgri_pkg::FUNC_ADD, 12'hfff, 16'h8000, 0, 0, 0, 0, 0), 0, '0);
        add_row(mk(wgri_pkg::FUNC_CLOSE, 0, 0, 12'hfff, 0, 12'h7ff, 0, 0), 1,
                res(wgri_pkg::ST_OK, 4096, 1));
        add_row(mk(wgri_pkg::FUNC_INTERP, 0, 0, 0, 0, 0, 0, 0), 0, '0);
        add_row(mk(wgri_pkg::FUNC_INTERP, 0, 0, 0, 0, 0, 0, 10'h3ff), 1,
                res(wgri_pkg::ST_BAD_IDX, 4096, 1));
        // Open, add, close a second group; then an empty close after open.
        add_row(mk(wgri_pkg::FUNC_OPEN, 0, 0, 0, 0, 0, 0, 0), 0, '0);
        add_row(mk(wgri_pkg::FUNC_ADD, 12'h555, 16'h0001, 0, 0, 0, 0, 0), 0, '0);
        add_row(mk(wgri_pkg::FUNC_ADD, 0, 16'h0000, 0, 0, 0, 0, 0), 0, '0);
        add_row(mk(wgri_pkg::FUNC_CLOSE, 0, 0, 1, 2, 3, 0, 0), 0, '0);
        add_row(mk(wgri_pkg::FUNC_OPEN, 0, 0, 0, 0, 0, 0, 0), 0, '0);
        add_row(mk(wgri_pkg::FUNC_CLOSE, 0, 0, 1, 2, 3, 0, 0), 1,
                res(wgri_pkg::ST_EMPTY, 4096, 2));
        add_row(mk(wgri_pkg::FUNC_INTERP, 0, 0, 0, 0, 0, 0, 1), 0, '0);
        add_row(mk(wgri_pkg::FUNC_WRITE, 12'h555, 0, 0, 0, 0, 24'hfedcba, 0), 0, '0);
        add_row(mk(wgri_pkg::FUNC_INTERP, 0, 0, 0, 0, 0, 0, 1), 0, '0);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < n_rows; i++) begin
            pace_sender();
            send_beat(directed[i].cmd);
            if (directed[i].has_result) begin
                typed = directed[i].result;
                if (exp_mem[exp_wr - 1] !== typed) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Directed row %0d: typed %h, predicted %h",
                                 i, typed, exp_mem[exp_wr - 1]);
                end
            end
        end

        // Random part: mostly well-formed groups, some noise and broken ones.
        n = 0;
        while (n < 400) begin
            kind = $urandom_range(0, 9);
            pace_sender();
            if (kind < 3) begin
                // Build a full group with random content.
                send_beat(mk(wgri_pkg::FUNC_OPEN, 0, 0, 0, 0, 0, 0, 0));
                repeat ($urandom_range(1, 14)) begin
                    it = rand_noise_fields();
                    it.func = wgri_pkg::FUNC_ADD;
                    if ($urandom_range(0, 3) == 0) it.weight = 16'hffff;
                    send_beat(it);
                    n++;
                    if (!pix_written[it.src_index]) begin
                        it.func = wgri_pkg::FUNC_WRITE;
                        send_beat(it);
                        n++;
                    end
                end
                it = rand_noise_fields();
                it.func = wgri_pkg::FUNC_CLOSE;
                send_beat(it);
                n += 2;
            end else if (kind < 7) begin
                if (grp_count > 0) begin
                    g = $urandom_range(0, grp_count - 1);
                    if (group_is_readable(g)) begin
                        it = rand_noise_fields();
                        it.func = wgri_pkg::FUNC_INTERP;
                        it.group_index = 10'(g);
                        send_beat(it);
                        n++;
                    end
                end
            end else if (kind == 7) begin
                it = rand_noise_fields();
                it.func = wgri_pkg::FUNC_WRITE;
                send_beat(it);
                n++;
            end else if (kind == 8) begin
                // Out-of-range interpolate or an empty close.
                it = rand_noise_fields();
                if ($urandom_range(0, 1) && grp_count < GRP_N) begin
                    it.func = wgri_pkg::FUNC_INTERP;
                    it.group_index = 10'($urandom_range(grp_count, GRP_N - 1));
                    send_beat(it);
                end else begin
                    send_beat(mk(wgri_pkg::FUNC_OPEN, 0, 0, 0, 0, 0, 0, 0));
                    it.func = wgri_pkg::FUNC_CLOSE;
                    send_beat(it);
                end
                n++;
            end else begin
                it = rand_noise_fields();
                it.func = wgri_pkg::func_t'(3'($urandom_range(5, 7)));
                send_beat(it);
                n++;
            end
        end
        s_valid <= 1'b0;

        // Drain, then wait for any stray beats.
        while (exp_rd < exp_wr) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (mismatches == 0 && exp_rd == exp_wr) begin
            $display("[weighted_gather_rgb_interpolator] OK");
        end else begin
            $display("[weighted_gather_rgb_interpolator] ERROR");
        end
        $finish;
    end

endmodule
